FILE: rtl/core/glos_pkg.sv
// Shared types and constants of the grid line-of-sight block.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package glos_pkg;

   localparam int COORD_W = 5;
   localparam int SIZE_W  = 6;
   localparam int LIM_W   = 9;
   localparam int ERR_W   = 9;

   localparam int MAX_X_DEF = 32;
   localparam int MAX_Y_DEF = 32;
   localparam int MAX_Z_DEF = 32;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;

   localparam logic [SIZE_W-1:0] X_SIZE_RST = 6'd32;
   localparam logic [SIZE_W-1:0] Y_SIZE_RST = 6'd32;
   localparam logic [SIZE_W-1:0] Z_SIZE_RST = 6'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_X_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_SIZE = 2'd2;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef logic [COORD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef struct packed {
      logic [SIZE_W-1:0] x_size;
      logic [SIZE_W-1:0] y_size;
      logic [SIZE_W-1:0] z_size;
   } cfg_type;

   // One classified transaction as held in the queue.
   typedef struct packed {
      logic      is_query;
      logic      blocked;
      logic      map_ok;
      coord_type x;
      coord_type y;
      coord_type z;
      coord_type da;
      coord_type db;
      coord_type dc;
      logic      dir_x;
      logic      dir_y;
      logic      dir_z;
      axis_type  axis;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

FILE: rtl/core/glos_front.sv
// Front end: accepts request transactions and classifies them into commands.
// Depends on glos_pkg.
`timescale 1ns / 1ps

module glos_front #(
   parameter int MAX_X = glos_pkg::MAX_X_DEF,
   parameter int MAX_Y = glos_pkg::MAX_Y_DEF,
   parameter int MAX_Z = glos_pkg::MAX_Z_DEF
) (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [glos_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [glos_pkg::REQ_USER_W-1:0] req_tuser,
   input  glos_pkg::q_stat_type            q_stat,
   input  logic                            clearing,
   output logic                            push,
   output glos_pkg::cmd_type               cmd
);
   import glos_pkg::*;

   localparam logic [LIM_W-1:0] LIM_X = LIM_W'(MAX_X);
   localparam logic [LIM_W-1:0] LIM_Y = LIM_W'(MAX_Y);
   localparam logic [LIM_W-1:0] LIM_Z = LIM_W'(MAX_Z);

   coord_type sx, sy, sz, ex, ey, ez;
   coord_type dx, dy, dz;

   assign sx = req_tdata[4:0];
   assign sy = req_tdata[9:5];
   assign sz = req_tdata[14:10];
   assign ex = req_tdata[19:15];
   assign ey = req_tdata[24:20];
   assign ez = req_tdata[29:25];

   assign dx = (ex > sx) ? ex - sx : sx - ex;
   assign dy = (ey > sy) ? ey - sy : sy - ey;
   assign dz = (ez > sz) ? ez - sz : sz - ez;

   assign req_tready = !q_stat.full && !clearing;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      cmd.is_query = (req_tuser[0] == MODE_QUERY);
      cmd.blocked  = req_tdata[30];
      cmd.map_ok   = ({4'b0, sx} < LIM_X) && ({4'b0, sy} < LIM_Y) && ({4'b0, sz} < LIM_Z);
      cmd.x        = sx;
      cmd.y        = sy;
      cmd.z        = sz;
      cmd.dir_x    = ex > sx;
      cmd.dir_y    = ey > sy;
      cmd.dir_z    = ez > sz;
      priority if (dx >= dy && dx >= dz) begin
         cmd.axis = AXIS_X;
         cmd.da   = dx;
         cmd.db   = dy;
         cmd.dc   = dz;
      end else if (dy >= dx && dy >= dz) begin
         cmd.axis = AXIS_Y;
         cmd.da   = dy;
         cmd.db   = dx;
         cmd.dc   = dz;
      end else begin
         cmd.axis = AXIS_Z;
         cmd.da   = dz;
         cmd.db   = dy;
         cmd.dc   = dx;
      end
   end

endmodule

FILE: rtl/core/glos_queue.sv
// Two-entry command queue between the front end and the walk engine.
// Depends on glos_pkg.
`timescale 1ns / 1ps

module glos_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  glos_pkg::cmd_type    cmd_in,
   input  logic                 pop,
   output glos_pkg::cmd_type    cmd_out,
   output glos_pkg::q_stat_type q_stat
);
   import glos_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);
   assign cmd_out      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

FILE: rtl/core/glos_back.sv
// Back end: obstacle map memory, map clearing pass and the Bresenham walk.
// Depends on glos_pkg.
`timescale 1ns / 1ps

module glos_back #(
   parameter int MAX_X = glos_pkg::MAX_X_DEF,
   parameter int MAX_Y = glos_pkg::MAX_Y_DEF,
   parameter int MAX_Z = glos_pkg::MAX_Z_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  glos_pkg::cfg_type    cfg,
   input  glos_pkg::cmd_type    cmd,
   input  glos_pkg::q_stat_type q_stat,
   output logic                 pop,
   output logic                 clearing,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_clear
);
   import glos_pkg::*;

   localparam int CELLS    = MAX_X * MAX_Y * MAX_Z;
   localparam int AW       = $clog2(CELLS);
   localparam int STRIDE_Y = MAX_X;
   localparam int STRIDE_Z = MAX_X * MAX_Y;

   localparam logic [AW-1:0]    LAST_ADDR = AW'(CELLS - 1);
   localparam logic [AW-1:0]    STEP_X    = AW'(1);
   localparam logic [AW-1:0]    STEP_Y    = AW'(STRIDE_Y);
   localparam logic [AW-1:0]    STEP_Z    = AW'(STRIDE_Z);
   localparam logic [LIM_W-1:0] LIM_X     = LIM_W'(MAX_X);
   localparam logic [LIM_W-1:0] LIM_Y     = LIM_W'(MAX_Y);
   localparam logic [LIM_W-1:0] LIM_Z     = LIM_W'(MAX_Z);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [AW-1:0]     clr_addr_ff;
   coord_type         x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [ERR_W-1:0]  e1_ff, e2_ff, e1_in, e2_in;
   coord_type         count_ff, da_ff, db_ff, dc_ff;
   logic              dir_x_ff, dir_y_ff, dir_z_ff;
   axis_type          axis_ff;
   logic              clear_ff;
   logic              chk_valid_ff, bound_ok_ff, bound_ok_in;
   logic              rd_data_ff;
   logic              rsp_valid_ff, rsp_clear_ff;

   logic              mem [CELLS];
   logic              mem_we, mem_wdata;
   logic [AW-1:0]     mem_waddr;
   logic [31:0]       start_lin;
   logic [AW-1:0]     start_addr;
   logic              step_x, step_y, step_z, step_b, step_c;
   logic [AW-1:0]     add_x, add_y, add_z;
   logic [ERR_W-1:0]  two_da, two_db, two_dc;

   assign clearing  = (state_ff == ST_CLEAR);
   assign pop       = (state_ff == ST_IDLE) && !q_stat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_clear = rsp_clear_ff;

   assign start_lin  = (32'(cmd.z) * 32'(MAX_Y) + 32'(cmd.y)) * 32'(MAX_X) + 32'(cmd.x);
   assign start_addr = start_lin[AW-1:0];

   assign mem_we    = clearing || (pop && !cmd.is_query && cmd.map_ok);
   assign mem_waddr = clearing ? clr_addr_ff : start_addr;
   assign mem_wdata = clearing ? 1'b0 : cmd.blocked;

   assign two_da = {3'b0, da_ff, 1'b0};
   assign two_db = {3'b0, db_ff, 1'b0};
   assign two_dc = {3'b0, dc_ff, 1'b0};
   assign step_b = !e1_ff[ERR_W-1];
   assign step_c = !e2_ff[ERR_W-1];

   always_comb begin
      unique case (axis_ff)
         AXIS_X: begin
            step_x = 1'b1;
            step_y = step_b;
            step_z = step_c;
         end
         AXIS_Y: begin
            step_x = step_b;
            step_y = 1'b1;
            step_z = step_c;
         end
         AXIS_Z: begin
            step_x = step_c;
            step_y = step_b;
            step_z = 1'b1;
         end
         default: begin
            step_x = 1'b0;
            step_y = 1'b0;
            step_z = 1'b0;
         end
      endcase

      x_in = step_x ? (dir_x_ff ? x_ff + 5'd1 : x_ff - 5'd1) : x_ff;
      y_in = step_y ? (dir_y_ff ? y_ff + 5'd1 : y_ff - 5'd1) : y_ff;
      z_in = step_z ? (dir_z_ff ? z_ff + 5'd1 : z_ff - 5'd1) : z_ff;

      add_x   = step_x ? (dir_x_ff ? STEP_X : AW'(0) - STEP_X) : AW'(0);
      add_y   = step_y ? (dir_y_ff ? STEP_Y : AW'(0) - STEP_Y) : AW'(0);
      add_z   = step_z ? (dir_z_ff ? STEP_Z : AW'(0) - STEP_Z) : AW'(0);
      addr_in = addr_ff + add_x + add_y + add_z;

      e1_in = e1_ff + two_db - (step_b ? two_da : ERR_W'(0));
      e2_in = e2_ff + two_dc - (step_c ? two_da : ERR_W'(0));

      bound_ok_in = ({1'b0, x_in} < cfg.x_size) && ({4'b0, x_in} < LIM_X)
                 && ({1'b0, y_in} < cfg.y_size) && ({4'b0, y_in} < LIM_Y)
                 && ({1'b0, z_in} < cfg.z_size) && ({4'b0, z_in} < LIM_Z);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chk_valid_ff <= (state_ff == ST_WALK);
         bound_ok_ff  <= bound_ok_in;
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (chk_valid_ff && (!bound_ok_ff || rd_data_ff)) begin
            clear_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (pop && cmd.is_query) begin
                  x_ff     <= cmd.x;
                  y_ff     <= cmd.y;
                  z_ff     <= cmd.z;
                  addr_ff  <= start_addr;
                  da_ff    <= cmd.da;
                  db_ff    <= cmd.db;
                  dc_ff    <= cmd.dc;
                  count_ff <= cmd.da;
                  dir_x_ff <= cmd.dir_x;
                  dir_y_ff <= cmd.dir_y;
                  dir_z_ff <= cmd.dir_z;
                  axis_ff  <= cmd.axis;
                  e1_ff    <= {3'b0, cmd.db, 1'b0} - {4'b0, cmd.da};
                  e2_ff    <= {3'b0, cmd.dc, 1'b0} - {4'b0, cmd.da};
                  clear_ff <= 1'b1;
                  state_ff <= (cmd.da == '0) ? ST_DONE : ST_WALK;
               end
            end
            ST_WALK: begin
               x_ff     <= x_in;
               y_ff     <= y_in;
               z_ff     <= z_in;
               addr_ff  <= addr_in;
               e1_ff    <= e1_in;
               e2_ff    <= e2_in;
               count_ff <= count_ff - 5'd1;
               if (count_ff == 5'd1) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_clear_ff <= clear_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: rtl/core/grid_line_of_sight_3d.sv
// Top level of the 3D grid line-of-sight block: size registers, front end,
// command queue and walk engine. Depends on glos_pkg, glos_front, glos_queue, glos_back.
//
//   Port group   Direction  Handshake               Contents
//   req_*        in         tvalid/tready           obstacle write or sight query
//   rsp_*        out        tvalid/tready           one result per query
//   csr_*        in         csr_we, no wait         x_size, y_size, z_size
//
// A write is stored from the queue head by the walk engine; a query walks along the
// longest of |dx|, |dy|, |dz| with one map read per stepped cell, and skips the walk
// when start and end coincide.
// After reset a clearing pass writes every map cell (MAX_X * MAX_Y * MAX_Z cells,
// 32768 by default), with req_tready low throughout.
// The two-entry queue holds up to two transactions while a query walks or a result waits.
`timescale 1ns / 1ps

module grid_line_of_sight_3d #(
   parameter int MAX_X = glos_pkg::MAX_X_DEF,
   parameter int MAX_Y = glos_pkg::MAX_Y_DEF,
   parameter int MAX_Z = glos_pkg::MAX_Z_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z, cell_blocked, zero pad
   input  logic [glos_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic [glos_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // clear_path, zero pad
   output logic [glos_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [glos_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [glos_pkg::SIZE_W-1:0]     csr_wdata
);
   import glos_pkg::*;

   cfg_type    cfg_ff;
   logic       clearing;
   logic       push, pop;
   cmd_type    cmd_front, cmd_head;
   q_stat_type q_stat;
   logic       rsp_clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_size <= X_SIZE_RST;
         cfg_ff.y_size <= Y_SIZE_RST;
         cfg_ff.z_size <= Z_SIZE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_X_SIZE: cfg_ff.x_size <= csr_wdata;
            CSR_Y_SIZE: cfg_ff.y_size <= csr_wdata;
            CSR_Z_SIZE: cfg_ff.z_size <= csr_wdata;
            default: ;
         endcase
      end
   end

   glos_front #(
      .MAX_X(MAX_X),
      .MAX_Y(MAX_Y),
      .MAX_Z(MAX_Z)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_stat    (q_stat),
      .clearing  (clearing),
      .push      (push),
      .cmd       (cmd_front)
   );

   glos_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .cmd_in (cmd_front),
      .pop    (pop),
      .cmd_out(cmd_head),
      .q_stat (q_stat)
   );

   glos_back #(
      .MAX_X(MAX_X),
      .MAX_Y(MAX_Y),
      .MAX_Z(MAX_Z)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .cmd      (cmd_head),
      .q_stat   (q_stat),
      .pop      (pop),
      .clearing (clearing),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_clear(rsp_clear)
   );

   assign rsp_tdata = {{(RSP_DATA_W - 1){1'b0}}, rsp_clear};

endmodule

FILE: tb/tb_grid_line_of_sight_3d.sv
// Self-checking testbench for grid_line_of_sight_3d: obstacle writes and sight queries
// are predicted by a behavioural 3D Bresenham walk and every result is compared in order.
// Depends on glos_pkg and the grid_line_of_sight_3d RTL only.
`timescale 1ns / 1ps

module tb_grid_line_of_sight_3d;
   import glos_pkg::*;

   localparam int GRID_CELLS    = MAX_X_DEF * MAX_Y_DEF * MAX_Z_DEF;
   localparam int STALL_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 80;
   localparam int PHASE_ITEMS   = 125;

   typedef struct {
      logic      mode;
      coord_type sx;
      coord_type sy;
      coord_type sz;
      coord_type ex;
      coord_type ey;
      coord_type ez;
      logic      blocked;
   } sight_item_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [SIZE_W-1:0]     csr_wdata  = '0;

   logic              obstacle_bits [GRID_CELLS];
   logic [SIZE_W-1:0] cfg_x_size = X_SIZE_RST;
   logic [SIZE_W-1:0] cfg_y_size = Y_SIZE_RST;
   logic [SIZE_W-1:0] cfg_z_size = Z_SIZE_RST;
   logic              clear_expected [$];
   logic              clear_wanted;
   int                send_idle_pct  = 0;
   int                stall_pct      = 0;
   int                errors         = 0;
   int                quiet_cycles   = 0;

   grid_line_of_sight_3d DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int size_limit(logic [SIZE_W-1:0] size, int max_cells);
      return (int'(size) > max_cells) ? max_cells : int'(size);
   endfunction

   function automatic int cell_number(int x, int y, int z);
      return (z * MAX_Y_DEF + y) * MAX_X_DEF + x;
   endfunction

   function automatic logic cell_passes(int x, int y, int z);
      if (x < 0 || x >= size_limit(cfg_x_size, MAX_X_DEF)) return 1'b0;
      if (y < 0 || y >= size_limit(cfg_y_size, MAX_Y_DEF)) return 1'b0;
      if (z < 0 || z >= size_limit(cfg_z_size, MAX_Z_DEF)) return 1'b0;
      return !obstacle_bits[cell_number(x, y, z)];
   endfunction

   function automatic logic predict_clear_path(sight_item_type it);
      int       pos [3];
      int       goal [3];
      int       delta [3];
      int       dir [3];
      int       a;
      int       b;
      int       c;
      int       err_b;
      int       err_c;
      int       k;
      axis_type dom;
      pos[0]  = int'(it.sx);
      pos[1]  = int'(it.sy);
      pos[2]  = int'(it.sz);
      goal[0] = int'(it.ex);
      goal[1] = int'(it.ey);
      goal[2] = int'(it.ez);
      for (k = 0; k < 3; k++) begin
         delta[k] = (goal[k] > pos[k]) ? goal[k] - pos[k] : pos[k] - goal[k];
         dir[k]   = (goal[k] > pos[k]) ? 1 : -1;
      end
      if (delta[0] >= delta[1] && delta[0] >= delta[2]) dom = AXIS_X;
      else if (delta[1] >= delta[0] && delta[1] >= delta[2]) dom = AXIS_Y;
      else dom = AXIS_Z;
      case (dom)
         AXIS_X: begin
            a = 0; b = 1; c = 2;
         end
         AXIS_Y: begin
            a = 1; b = 0; c = 2;
         end
         default: begin
            a = 2; b = 1; c = 0;
         end
      endcase
      err_b = 2 * delta[b] - delta[a];
      err_c = 2 * delta[c] - delta[a];
      while (pos[a] != goal[a]) begin
         pos[a] += dir[a];
         if (err_b >= 0) begin
            pos[b] += dir[b];
            err_b  -= 2 * delta[a];
         end
         if (err_c >= 0) begin
            pos[c] += dir[c];
            err_c  -= 2 * delta[a];
         end
         err_b += 2 * delta[b];
         err_c += 2 * delta[c];
         if (!cell_passes(pos[0], pos[1], pos[2])) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic coord_type grid_coord(logic [SIZE_W-1:0] size, int max_cells);
      int span;
      span = size_limit(size, max_cells);
      return (span == 0) ? coord_type'($urandom_range(31)) : coord_type'($urandom_range(span - 1));
   endfunction

   function automatic sight_item_type random_item();
      sight_item_type it;
      logic           well_formed;
      it.mode     = ($urandom_range(99) < 35) ? MODE_WRITE : MODE_QUERY;
      it.blocked  = ($urandom_range(99) < 65);
      well_formed = ($urandom_range(99) < 80);
      if (well_formed) begin
         it.sx = grid_coord(cfg_x_size, MAX_X_DEF);
         it.sy = grid_coord(cfg_y_size, MAX_Y_DEF);
         it.sz = grid_coord(cfg_z_size, MAX_Z_DEF);
         it.ex = grid_coord(cfg_x_size, MAX_X_DEF);
         it.ey = grid_coord(cfg_y_size, MAX_Y_DEF);
         it.ez = grid_coord(cfg_z_size, MAX_Z_DEF);
      end else begin
         it.sx = coord_type'($urandom_range(31));
         it.sy = coord_type'($urandom_range(31));
         it.sz = coord_type'($urandom_range(31));
         it.ex = coord_type'($urandom_range(31));
         it.ey = coord_type'($urandom_range(31));
         it.ez = coord_type'($urandom_range(31));
      end
      if (it.mode == MODE_QUERY && $urandom_range(99) < 5) begin
         it.ex = it.sx;
         it.ey = it.sy;
         it.ez = it.sz;
      end
      return it;
   endfunction

   // Holds one transaction on the request channel until it is accepted, then predicts it.
   task automatic send_item(sight_item_type it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, it.blocked, it.ez, it.ey, it.ex, it.sz, it.sy, it.sx};
      req_tuser  <= it.mode;
      do @(posedge clock); while (!req_tready);
      if (it.mode == MODE_QUERY) begin
         clear_expected = {clear_expected, predict_clear_path(it)};
      end else if (it.sx < MAX_X_DEF && it.sy < MAX_Y_DEF && it.sz < MAX_Z_DEF) begin
         obstacle_bits[cell_number(int'(it.sx), int'(it.sy), int'(it.sz))] = it.blocked;
      end
   endtask

   task automatic query(int sx, int sy, int sz, int ex, int ey, int ez);
      sight_item_type it;
      it.mode    = MODE_QUERY;
      it.sx      = coord_type'(sx);
      it.sy      = coord_type'(sy);
      it.sz      = coord_type'(sz);
      it.ex      = coord_type'(ex);
      it.ey      = coord_type'(ey);
      it.ez      = coord_type'(ez);
      it.blocked = 1'b0;
      send_item(it);
   endtask

   task automatic put_cell(int x, int y, int z, logic blocked);
      sight_item_type it;
      it.mode    = MODE_WRITE;
      it.sx      = coord_type'(x);
      it.sy      = coord_type'(y);
      it.sz      = coord_type'(z);
      it.ex      = coord_type'(31 - x);
      it.ey      = coord_type'(31 - y);
      it.ez      = coord_type'(31 - z);
      it.blocked = blocked;
      send_item(it);
   endtask

   // Stops the request stream and lets every outstanding query and write finish.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (clear_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_sizes(logic [SIZE_W-1:0] xs, logic [SIZE_W-1:0] ys,
                            logic [SIZE_W-1:0] zs);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_X_SIZE;
      csr_wdata <= xs;
      @(negedge clock);
      csr_index <= CSR_Y_SIZE;
      csr_wdata <= ys;
      @(negedge clock);
      csr_index <= CSR_Z_SIZE;
      csr_wdata <= zs;
      @(negedge clock);
      csr_we     <= 1'b0;
      cfg_x_size = xs;
      cfg_y_size = ys;
      cfg_z_size = zs;
   endtask

   task automatic test_directed_paths();
      query(31, 31, 31, 31, 31, 31);
      put_cell(5, 5, 0, 1'b1);
      query(5, 5, 0, 5, 5, 0);
      query(5, 5, 0, 0, 0, 0);
      query(0, 5, 0, 10, 5, 0);
      query(10, 5, 0, 0, 5, 0);
      put_cell(5, 5, 0, 1'b0);
      query(0, 5, 0, 10, 5, 0);
      query(0, 0, 0, 31, 31, 0);
      query(0, 0, 0, 3, 31, 0);
      query(0, 0, 0, 0, 0, 1);
      query(31, 31, 0, 0, 0, 0);
      put_cell(31, 31, 31, 1'b1);
      query(0, 31, 0, 31, 0, 0);
      settle();
   endtask

   task automatic test_size_extremes();
      set_sizes(6'd63, 6'd63, 6'd63);
      query(0, 0, 0, 31, 31, 31);
      query(0, 0, 0, 30, 30, 30);
      query(0, 0, 0, 2, 5, 31);
      query(31, 31, 31, 0, 0, 0);
      settle();
      set_sizes(6'd0, 6'd0, 6'd0);
      query(1, 1, 1, 2, 2, 2);
      query(1, 1, 1, 1, 1, 1);
      settle();
      set_sizes(6'd1, 6'd1, 6'd1);
      query(0, 0, 0, 1, 0, 0);
      query(1, 1, 1, 0, 0, 0);
      settle();
      set_sizes(6'd32, 6'd32, 6'd32);
      put_cell(31, 31, 31, 1'b0);
      query(31, 0, 31, 0, 31, 0);
      settle();
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_level);
      logic [SIZE_W-1:0] sizes [3];
      int                k;
      for (k = 0; k < 3; k++) begin
         if ($urandom_range(99) < 15) sizes[k] = SIZE_W'($urandom_range(63));
         else if (k == 2) sizes[k] = SIZE_W'($urandom_range(1, 8));
         else sizes[k] = SIZE_W'($urandom_range(2, 16));
      end
      set_sizes(sizes[0], sizes[1], sizes[2]);
      send_idle_pct = idle_pct;
      stall_pct     = stall_level;
      for (k = 0; k < PHASE_ITEMS; k++) send_item(random_item());
      settle();
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (clear_expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual clear_path %0b",
                     $time, rsp_tdata[0]);
         end else begin
            clear_wanted = clear_expected.pop_front();
            if (rsp_tdata[0] !== clear_wanted) begin
               errors++;
               $display("%0t: clear_path mismatch, expected %0b, actual %0b",
                        $time, clear_wanted, rsp_tdata[0]);
            end
         end
      end
   end

   // The clearing pass after reset keeps req_tready low for a whole map sweep.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      foreach (obstacle_bits[i]) obstacle_bits[i] = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_directed_paths();
      test_size_extremes();
      test_random_traffic(0, 0);
      test_random_traffic(59, 0);
      test_random_traffic(0, 59);
      test_random_traffic(16, 16);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
